// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/tadp_pkg.sv =====
package tadp_pkg;

   localparam int AZ_DEG_BITS    = 9;
   localparam int EL_DEG_BITS    = 8;
   localparam int SCALE_BITS     = 16;
   localparam int ACTION_BITS    = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [ACTION_BITS-1:0] ACT_TICK = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_BOTH = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_AZ   = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_EL   = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_AZ_ZERO  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AZ_MAX   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EL_ZERO  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EL_MAX   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AZ_BAND  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EL_BAND  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AZ_SCALE = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EL_SCALE = 3'd7;

   localparam logic [SCALE_BITS-1:0] AZ_SCALE_RESET = 16'd9312;
   localparam logic [SCALE_BITS-1:0] EL_SCALE_RESET = 16'd23279;

   localparam int MAX_COUNT_RESET = 1023;
   localparam int DEAD_BAND_RESET = 4;

   typedef struct packed {
      logic active;
      logic up;
      logic down;
   } axis_ctl_type;

endpackage

// ===== rtl/tadp_axis.sv =====
module tadp_axis #(
   parameter int SENSOR_BITS     = 10,
   parameter int SCALE_FRAC_BITS = 12,
   parameter int PROD_BITS       = 25
) (
   input  logic [PROD_BITS-1:0]   prod,
   input  logic                   cmd,
   input  logic [SENSOR_BITS-1:0] reading,
   input  logic [SENSOR_BITS-1:0] zero_count,
   input  logic [SENSOR_BITS-1:0] max_count,
   input  logic [SENSOR_BITS-1:0] dead_band,
   input  logic [SENSOR_BITS-1:0] goal_cur,
   input  logic                   active_cur,
   output logic [SENSOR_BITS-1:0] goal_next,
   output tadp_pkg::axis_ctl_type ctl
);
   import tadp_pkg::*;

   localparam int SUM_BITS = PROD_BITS + 2;

   logic [SUM_BITS-1:0]    round_sum;
   logic [SUM_BITS-1:0]    count_raw;
   logic [SUM_BITS-1:0]    count_hi;
   logic [SUM_BITS-1:0]    count_clamp;
   logic [SENSOR_BITS-1:0] goal_cmd;
   logic [SENSOR_BITS-1:0] err;
   logic                   outside;
   logic                   act_now;

   always_comb begin
      round_sum   = SUM_BITS'(prod) + (SUM_BITS'(1) << (SCALE_FRAC_BITS - 1));
      count_raw   = (round_sum >> SCALE_FRAC_BITS) + SUM_BITS'(zero_count);
      count_hi    = (count_raw > SUM_BITS'(max_count)) ? SUM_BITS'(max_count) : count_raw;
      count_clamp = (count_hi < SUM_BITS'(zero_count)) ? SUM_BITS'(zero_count) : count_hi;
      goal_cmd    = count_clamp[SENSOR_BITS-1:0];
      err         = (goal_cmd > reading) ? (goal_cmd - reading) : (reading - goal_cmd);
      outside     = err > dead_band;
      goal_next   = cmd ? goal_cmd : goal_cur;
      act_now     = cmd ? outside : active_cur;
      ctl.active  = act_now && (reading != goal_next);
      ctl.up      = ctl.active && (reading < goal_next);
      ctl.down    = ctl.active && (reading > goal_next);
   end

endmodule

// ===== rtl/two_axis_deadband_positioner.sv =====
// Two-axis bang-bang positioner with per-axis dead band. One transaction is
// taken every clock cycle while the result is not stalled: the degree-to-count
// products are registered at acceptance, then rounding, zero offset, clamping,
// dead-band test and drive decision run into the result register while the goal
// and busy state update. A stalled result holds one transaction in the product
// stage; further input stalls until the result is taken. The user must write the
// configuration registers through the csr port only while no transaction is in
// flight; the block itself does not enforce this. They have no read-back.
module two_axis_deadband_positioner #(
   parameter int SENSOR_BITS     = 10,
   parameter int SCALE_FRAC_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [tadp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tadp_pkg::CSR_DATA_BITS-1:0]    csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [tadp_pkg::ACTION_BITS-1:0]      req_action,
   input  logic [tadp_pkg::AZ_DEG_BITS-1:0]      req_target_az_deg,
   input  logic [tadp_pkg::EL_DEG_BITS-1:0]      req_target_el_deg,
   input  logic [SENSOR_BITS-1:0]                req_az_reading,
   input  logic [SENSOR_BITS-1:0]                req_el_reading,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_drive_east,
   output logic                                  rsp_drive_west,
   output logic                                  rsp_drive_up,
   output logic                                  rsp_drive_down,
   output logic                                  rsp_az_busy,
   output logic                                  rsp_el_busy,
   output logic [SENSOR_BITS-1:0]                rsp_az_goal_count,
   output logic [SENSOR_BITS-1:0]                rsp_el_goal_count
);
   import tadp_pkg::*;
   `include "assert_macros.svh"

   localparam int AZ_PROD_BITS = AZ_DEG_BITS + SCALE_BITS;
   localparam int EL_PROD_BITS = EL_DEG_BITS + SCALE_BITS;

   // configuration
   logic [SENSOR_BITS-1:0] az_zero_ff, az_max_ff, el_zero_ff, el_max_ff;
   logic [SENSOR_BITS-1:0] az_band_ff, el_band_ff;
   logic [SCALE_BITS-1:0]  az_scale_ff, el_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         az_zero_ff  <= '0;
         az_max_ff   <= SENSOR_BITS'(MAX_COUNT_RESET);
         el_zero_ff  <= '0;
         el_max_ff   <= SENSOR_BITS'(MAX_COUNT_RESET);
         az_band_ff  <= SENSOR_BITS'(DEAD_BAND_RESET);
         el_band_ff  <= SENSOR_BITS'(DEAD_BAND_RESET);
         az_scale_ff <= AZ_SCALE_RESET;
         el_scale_ff <= EL_SCALE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_AZ_ZERO:  az_zero_ff  <= csr_wr_data[SENSOR_BITS-1:0];
            CSR_AZ_MAX:   az_max_ff   <= csr_wr_data[SENSOR_BITS-1:0];
            CSR_EL_ZERO:  el_zero_ff  <= csr_wr_data[SENSOR_BITS-1:0];
            CSR_EL_MAX:   el_max_ff   <= csr_wr_data[SENSOR_BITS-1:0];
            CSR_AZ_BAND:  az_band_ff  <= csr_wr_data[SENSOR_BITS-1:0];
            CSR_EL_BAND:  el_band_ff  <= csr_wr_data[SENSOR_BITS-1:0];
            CSR_AZ_SCALE: az_scale_ff <= csr_wr_data[SCALE_BITS-1:0];
            CSR_EL_SCALE: el_scale_ff <= csr_wr_data[SCALE_BITS-1:0];
         endcase
      end
   end

   // handshake
   logic a_vld_ff;
   logic o_vld_ff;
   logic out_free;
   logic a_move;
   logic req_take;

   assign out_free  = !o_vld_ff || !rsp_stall;
   assign a_move    = a_vld_ff && out_free;
   assign req_stall = a_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = o_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         if (req_take) begin
            a_vld_ff <= 1'b1;
         end else if (a_move) begin
            a_vld_ff <= 1'b0;
         end
         if (a_move) begin
            o_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            o_vld_ff <= 1'b0;
         end
      end
   end

   // product stage
   logic [AZ_PROD_BITS-1:0] a_az_prod_ff, a_az_prod_in;
   logic [EL_PROD_BITS-1:0] a_el_prod_ff, a_el_prod_in;
   logic                    a_az_cmd_ff, a_el_cmd_ff;
   logic [SENSOR_BITS-1:0]  a_az_rd_ff, a_el_rd_ff;

   assign a_az_prod_in = AZ_PROD_BITS'(req_target_az_deg) * AZ_PROD_BITS'(az_scale_ff);
   assign a_el_prod_in = EL_PROD_BITS'(req_target_el_deg) * EL_PROD_BITS'(el_scale_ff);

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_az_prod_ff <= a_az_prod_in;
         a_el_prod_ff <= a_el_prod_in;
         a_az_cmd_ff  <= (req_action == ACT_BOTH) || (req_action == ACT_AZ);
         a_el_cmd_ff  <= (req_action == ACT_BOTH) || (req_action == ACT_EL);
         a_az_rd_ff   <= req_az_reading;
         a_el_rd_ff   <= req_el_reading;
      end
   end

   // axis decisions
   logic [SENSOR_BITS-1:0] az_goal_ff, el_goal_ff;
   logic                   az_active_ff, el_active_ff;
   logic [SENSOR_BITS-1:0] az_goal_in, el_goal_in;
   axis_ctl_type           az_ctl, el_ctl;

   tadp_axis #(
      .SENSOR_BITS     (SENSOR_BITS),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
      .PROD_BITS       (AZ_PROD_BITS)
   ) u_az_axis (
      .prod       (a_az_prod_ff),
      .cmd        (a_az_cmd_ff),
      .reading    (a_az_rd_ff),
      .zero_count (az_zero_ff),
      .max_count  (az_max_ff),
      .dead_band  (az_band_ff),
      .goal_cur   (az_goal_ff),
      .active_cur (az_active_ff),
      .goal_next  (az_goal_in),
      .ctl        (az_ctl)
   );

   tadp_axis #(
      .SENSOR_BITS     (SENSOR_BITS),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
      .PROD_BITS       (EL_PROD_BITS)
   ) u_el_axis (
      .prod       (a_el_prod_ff),
      .cmd        (a_el_cmd_ff),
      .reading    (a_el_rd_ff),
      .zero_count (el_zero_ff),
      .max_count  (el_max_ff),
      .dead_band  (el_band_ff),
      .goal_cur   (el_goal_ff),
      .active_cur (el_active_ff),
      .goal_next  (el_goal_in),
      .ctl        (el_ctl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         az_goal_ff   <= '0;
         el_goal_ff   <= '0;
         az_active_ff <= 1'b0;
         el_active_ff <= 1'b0;
      end else if (a_move) begin
         az_goal_ff   <= az_goal_in;
         el_goal_ff   <= el_goal_in;
         az_active_ff <= az_ctl.active;
         el_active_ff <= el_ctl.active;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (a_move) begin
         rsp_drive_east    <= az_ctl.up;
         rsp_drive_west    <= az_ctl.down;
         rsp_drive_up      <= el_ctl.up;
         rsp_drive_down    <= el_ctl.down;
         rsp_az_busy       <= az_ctl.active;
         rsp_el_busy       <= el_ctl.active;
         rsp_az_goal_count <= az_goal_in;
         rsp_el_goal_count <= el_goal_in;
      end
   end

   `ASSERT_CLK(a_az_drive_busy, rsp_valid |-> ((rsp_drive_east || rsp_drive_west) == rsp_az_busy) && !(rsp_drive_east && rsp_drive_west), "azimuth drive disagrees with busy")
   `ASSERT_CLK(a_el_drive_busy, rsp_valid |-> ((rsp_drive_up || rsp_drive_down) == rsp_el_busy) && !(rsp_drive_up && rsp_drive_down), "elevation drive disagrees with busy")
   `ASSERT_ALWAYS(a_goal_hold, (!reset && !a_move) |=> ($stable(az_goal_ff) && $stable(el_goal_ff)), "goal changed without a transaction")

endmodule

// ===== test/positioner_drive_checker.sv =====
module positioner_drive_checker #(
   parameter int SENSOR_BITS     = 10,
   parameter int SCALE_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tadp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tadp_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [tadp_pkg::ACTION_BITS-1:0]    req_action,
   input  logic [tadp_pkg::AZ_DEG_BITS-1:0]    req_target_az_deg,
   input  logic [tadp_pkg::EL_DEG_BITS-1:0]    req_target_el_deg,
   input  logic [SENSOR_BITS-1:0]              req_az_reading,
   input  logic [SENSOR_BITS-1:0]              req_el_reading,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_drive_east,
   input  logic                                rsp_drive_west,
   input  logic                                rsp_drive_up,
   input  logic                                rsp_drive_down,
   input  logic                                rsp_az_busy,
   input  logic                                rsp_el_busy,
   input  logic [SENSOR_BITS-1:0]              rsp_az_goal_count,
   input  logic [SENSOR_BITS-1:0]              rsp_el_goal_count,
   output int                                  mismatch_count,
   output int                                  pending_results
);
   import tadp_pkg::*;

   typedef logic [SENSOR_BITS-1:0] count_type;

   typedef struct packed {
      logic      drive_east;
      logic      drive_west;
      logic      drive_up;
      logic      drive_down;
      logic      az_busy;
      logic      el_busy;
      count_type az_goal_count;
      count_type el_goal_count;
   } drive_result_type;

   count_type az_zero, az_max, el_zero, el_max, az_band, el_band;
   logic [SCALE_BITS-1:0] az_scale, el_scale;
   count_type az_goal, el_goal;
   logic az_moving, el_moving;
   drive_result_type drive_expect_q[$];

   initial mismatch_count = 0;
   initial pending_results = 0;

   function automatic count_type degrees_to_count(input int unsigned deg,
                                                  input logic [SCALE_BITS-1:0] scale,
                                                  input count_type zero,
                                                  input count_type ceiling);
      int unsigned counts;
      counts = (deg * 32'(scale) + (32'd1 << (SCALE_FRAC_BITS - 1))) >> SCALE_FRAC_BITS;
      counts = counts + 32'(zero);
      if (counts > 32'(ceiling)) counts = 32'(ceiling);
      if (counts < 32'(zero)) counts = 32'(zero);
      return count_type'(counts);
   endfunction

   function automatic logic outside_band(input count_type goal, input count_type reading,
                                         input count_type band);
      count_type err;
      err = (goal > reading) ? goal - reading : reading - goal;
      return err > band;
   endfunction

   task automatic steer_axis(inout logic moving, input count_type goal,
                             input count_type reading,
                             output logic toward_high, output logic toward_low);
      toward_high = 1'b0;
      toward_low  = 1'b0;
      if (moving) begin
         if (reading == goal) moving = 1'b0;
         else if (reading < goal) toward_high = 1'b1;
         else toward_low = 1'b1;
      end
   endtask

   task automatic predict_drive(input logic [ACTION_BITS-1:0] action,
                                input logic [AZ_DEG_BITS-1:0] az_deg,
                                input logic [EL_DEG_BITS-1:0] el_deg,
                                input count_type az_reading, input count_type el_reading);
      drive_result_type result;
      result = '0;
      if (action == ACT_BOTH || action == ACT_AZ) begin
         az_goal   = degrees_to_count(az_deg, az_scale, az_zero, az_max);
         az_moving = outside_band(az_goal, az_reading, az_band);
      end
      if (action == ACT_BOTH || action == ACT_EL) begin
         el_goal   = degrees_to_count(el_deg, el_scale, el_zero, el_max);
         el_moving = outside_band(el_goal, el_reading, el_band);
      end
      steer_axis(az_moving, az_goal, az_reading, result.drive_east, result.drive_west);
      steer_axis(el_moving, el_goal, el_reading, result.drive_up, result.drive_down);
      result.az_busy       = az_moving;
      result.el_busy       = el_moving;
      result.az_goal_count = az_goal;
      result.el_goal_count = el_goal;
      drive_expect_q.push_back(result);
   endtask

   task automatic note_failure(input string what, input drive_result_type want,
                               input drive_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t %s: expected e%0b w%0b u%0b d%0b busy %0b%0b goal %0d/%0d,",
                   " got e%0b w%0b u%0b d%0b busy %0b%0b goal %0d/%0d"},
                  $realtime, what,
                  want.drive_east, want.drive_west, want.drive_up, want.drive_down,
                  want.az_busy, want.el_busy, want.az_goal_count, want.el_goal_count,
                  got.drive_east, got.drive_west, got.drive_up, got.drive_down,
                  got.az_busy, got.el_busy, got.az_goal_count, got.el_goal_count);
   endtask

   always @(posedge clock) begin
      drive_result_type got;
      drive_result_type want;
      if (reset) begin
         az_zero   = '0;
         az_max    = count_type'(MAX_COUNT_RESET);
         el_zero   = '0;
         el_max    = count_type'(MAX_COUNT_RESET);
         az_band   = count_type'(DEAD_BAND_RESET);
         el_band   = count_type'(DEAD_BAND_RESET);
         az_scale  = AZ_SCALE_RESET;
         el_scale  = EL_SCALE_RESET;
         az_goal   = '0;
         el_goal   = '0;
         az_moving = 1'b0;
         el_moving = 1'b0;
         drive_expect_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_AZ_ZERO:  az_zero  = csr_wr_data[SENSOR_BITS-1:0];
               CSR_AZ_MAX:   az_max   = csr_wr_data[SENSOR_BITS-1:0];
               CSR_EL_ZERO:  el_zero  = csr_wr_data[SENSOR_BITS-1:0];
               CSR_EL_MAX:   el_max   = csr_wr_data[SENSOR_BITS-1:0];
               CSR_AZ_BAND:  az_band  = csr_wr_data[SENSOR_BITS-1:0];
               CSR_EL_BAND:  el_band  = csr_wr_data[SENSOR_BITS-1:0];
               CSR_AZ_SCALE: az_scale = csr_wr_data[SCALE_BITS-1:0];
               CSR_EL_SCALE: el_scale = csr_wr_data[SCALE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_drive_east, rsp_drive_west, rsp_drive_up, rsp_drive_down,
                    rsp_az_busy, rsp_el_busy, rsp_az_goal_count, rsp_el_goal_count};
            if (drive_expect_q.size() == 0) begin
               note_failure("unexpected transaction", '0, got);
            end else begin
               want = drive_expect_q.pop_front();
               if (got.drive_east !== want.drive_east || got.drive_west !== want.drive_west ||
                   got.drive_up !== want.drive_up || got.drive_down !== want.drive_down ||
                   got.az_busy !== want.az_busy || got.el_busy !== want.el_busy ||
                   got.az_goal_count !== want.az_goal_count ||
                   got.el_goal_count !== want.el_goal_count)
                  note_failure("mismatch", want, got);
            end
         end
         if (req_valid && !req_stall)
            predict_drive(req_action, req_target_az_deg, req_target_el_deg,
                          req_az_reading, req_el_reading);
      end
      pending_results <= drive_expect_q.size();
   end

endmodule

// ===== test/two_axis_deadband_positioner_tb.sv =====
module two_axis_deadband_positioner_tb;
   import tadp_pkg::*;

   localparam int SENSOR_BITS     = 10;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 135;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ORDER [8] = '{
      CSR_AZ_ZERO, CSR_AZ_MAX, CSR_EL_ZERO, CSR_EL_MAX,
      CSR_AZ_BAND, CSR_EL_BAND, CSR_AZ_SCALE, CSR_EL_SCALE};
   localparam logic [ACTION_BITS-1:0] COMMANDS [3] = '{ACT_BOTH, ACT_AZ, ACT_EL};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_AZ_ZERO;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [ACTION_BITS-1:0]    req_action = ACT_TICK;
   logic [AZ_DEG_BITS-1:0]    req_target_az_deg = '0;
   logic [EL_DEG_BITS-1:0]    req_target_el_deg = '0;
   logic [SENSOR_BITS-1:0]    req_az_reading = '0;
   logic [SENSOR_BITS-1:0]    req_el_reading = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_drive_east, rsp_drive_west, rsp_drive_up, rsp_drive_down;
   logic                      rsp_az_busy, rsp_el_busy;
   logic [SENSOR_BITS-1:0]    rsp_az_goal_count, rsp_el_goal_count;

   int mismatch_count;
   int pending_results;
   int idle_cycles = 0;
   logic steady = 1'b0;
   logic [SENSOR_BITS-1:0] seen_az_goal = '0;
   logic [SENSOR_BITS-1:0] seen_el_goal = '0;
   int az_pos = 0;
   int el_pos = 0;
   int az_last_deg = 0;
   int el_last_deg = 0;

   two_axis_deadband_positioner i_dut (.*);

   positioner_drive_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 11);
   end

   // plant model follows the goals the block reports
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         seen_az_goal <= rsp_az_goal_count;
         seen_el_goal <= rsp_el_goal_count;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_transaction(input logic [ACTION_BITS-1:0] action, input int az_deg,
                                   input int el_deg, input int az_rd, input int el_rd);
      while (!steady && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= action;
      req_target_az_deg <= AZ_DEG_BITS'(az_deg);
      req_target_el_deg <= EL_DEG_BITS'(el_deg);
      req_az_reading    <= SENSOR_BITS'(az_rd);
      req_el_reading    <= SENSOR_BITS'(el_rd);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CSR_DATA_BITS-1:0] values [8]);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= REG_ORDER[i];
         csr_wr_data <= values[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure_phase(input int phase);
      logic [CSR_DATA_BITS-1:0] v [8];
      int lo;
      case (phase)
         0: v = '{16'd0, 16'd1023, 16'd0, 16'd1023, 16'd4, 16'd4,
                  AZ_SCALE_RESET, EL_SCALE_RESET};
         // max below zero point, zero and full scale
         1: v = '{16'd1023, 16'd0, 16'd900, 16'd100, 16'd0, 16'd1023, 16'hFFFF, 16'd0};
         2: v = '{16'd0, 16'd1023, 16'd0, 16'd1023, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
         3: v = '{16'd0, 16'd0, 16'd1023, 16'd1023, 16'd1023, 16'd0, 16'd0, 16'h8000};
         default: begin
            lo = $urandom_range(0, 200);
            v[0] = 16'(lo);
            v[1] = 16'($urandom_range(lo, 1023));
            lo = $urandom_range(0, 200);
            v[2] = 16'(lo);
            v[3] = 16'($urandom_range(lo, 1023));
            v[4] = 16'($urandom_range(0, 12));
            v[5] = 16'($urandom_range(0, 12));
            v[6] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1000, 30000));
            v[7] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1000, 30000));
         end
      endcase
      for (int i = 0; i < 6; i++)
         if ($urandom_range(0, 1) == 1) v[i][CSR_DATA_BITS-1:SENSOR_BITS] = 6'($urandom);
      write_registers(v);
   endtask

   function automatic int clamp_count(input int value);
      if (value < 0) return 0;
      if (value > 1023) return 1023;
      return value;
   endfunction

   function automatic int step_toward(input int pos, input int goal);
      int stride;
      stride = $urandom_range(1, 4);
      if ($urandom_range(0, 19) == 0) return clamp_count(pos + $urandom_range(0, 8) - 4);
      if (pos < goal) return (goal - pos <= stride) ? goal : pos + stride;
      if (pos > goal) return (pos - goal <= stride) ? goal : pos - stride;
      return pos;
   endfunction

   task automatic random_transaction();
      int r;
      int az_deg;
      int el_deg;
      logic [ACTION_BITS-1:0] action;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         send_transaction(ACTION_BITS'($urandom_range(0, 3)), $urandom_range(0, 511),
                          $urandom_range(0, 255), $urandom_range(0, 1023),
                          $urandom_range(0, 1023));
      end else begin
         action = (r < 45) ? COMMANDS[$urandom_range(0, 2)] : ACT_TICK;
         case ($urandom_range(0, 7))
            0:       az_deg = $urandom_range(0, 511);
            1, 2, 3: az_deg = $urandom_range(0, 450);
            default: az_deg = (az_last_deg + $urandom_range(0, 6) + 509) % 512;
         endcase
         case ($urandom_range(0, 7))
            0:       el_deg = $urandom_range(0, 255);
            1, 2, 3: el_deg = $urandom_range(0, 180);
            default: el_deg = (el_last_deg + $urandom_range(0, 6) + 253) % 256;
         endcase
         if (action != ACT_TICK) begin
            az_last_deg = az_deg;
            el_last_deg = el_deg;
         end
         send_transaction(action, az_deg, el_deg, az_pos, el_pos);
      end
      az_pos = step_toward(az_pos, seen_az_goal);
      el_pos = step_toward(el_pos, seen_el_goal);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_transaction(ACT_TICK, 0, 0, 0, 0);
      send_transaction(ACT_BOTH, 450, 180, 0, 0);
      send_transaction(ACT_TICK, 0, 0, 512, 512);
      send_transaction(ACT_BOTH, 511, 255, 1023, 1023);
      send_transaction(ACT_AZ, 100, 255, 1023, 0);
      send_transaction(ACT_EL, 511, 40, 1023, 1023);
      drain_results();
      send_transaction(ACT_TICK, 0, 0, seen_az_goal, seen_el_goal);
      // dead band edges, then one axis in band while the other moves
      send_transaction(ACT_BOTH, 100, 40, seen_az_goal + 4, seen_el_goal - 4);
      send_transaction(ACT_BOTH, 100, 40, seen_az_goal + 5, seen_el_goal);
      send_transaction(ACT_TICK, 0, 0, seen_az_goal + 1, seen_el_goal + 3);
      send_transaction(ACT_BOTH, 100, 40, seen_az_goal, seen_el_goal - 5);
      send_transaction(ACT_TICK, 0, 0, seen_az_goal, seen_el_goal);
      send_transaction(ACT_BOTH, 0, 0, 1023, 1023);
      send_transaction(ACT_TICK, 0, 0, 0, 1023);
      send_transaction(ACT_TICK, 0, 0, 1023, 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         configure_phase(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            steady <= (phase == 2 && n < 100);
            if (phase == 4 && n == 70) drain_results();
            random_transaction();
         end
      end
      steady <= 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tadp_pkg.sv
rtl/tadp_axis.sv
rtl/two_axis_deadband_positioner.sv
test/positioner_drive_checker.sv
test/two_axis_deadband_positioner_tb.sv
